// ----- design/lrupr_pkg.sv -----
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared widths, reset values and the controller command bundle for the
// LRU page replacement block.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  localparam int CFG_W      = 5;
  localparam int PAGE_W     = 16;
  localparam int FRAME_IDX_W = 4;
  localparam int FAULT_W    = 32;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

  localparam logic ACT_REF   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic capture;
    logic look;
    logic update;
  } cmd_t;

endpackage

// ----- design/lrupr_req_if.sv -----
// ----------------------------------------------------------------------------
// lrupr_req_if
// Request channel: one page reference or clear action per item.
// ----------------------------------------------------------------------------
interface lrupr_req_if;

  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [lrupr_pkg::PAGE_W-1:0]  page_number;

  modport source (output valid, output action, output page_number, input ready);
  modport sink   (input valid, input action, input page_number, output ready);

endinterface

// ----- design/lrupr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lrupr_rsp_if
// Response channel: one lookup result per item.
// ----------------------------------------------------------------------------
interface lrupr_rsp_if;

  logic                               valid;
  logic                               ready;
  logic                               hit;
  logic [lrupr_pkg::FRAME_IDX_W-1:0]  frame_index;
  logic                               evicted_valid;
  logic [lrupr_pkg::PAGE_W-1:0]       evicted_page;
  logic [lrupr_pkg::FAULT_W-1:0]      fault_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_count, output ready);

endinterface

// ----- design/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page frame manager: tag lookup, fill of free frames, eviction of the
// least recently used frame, saturating fault count.
// A request passes the capture, lookup and update states in order; the response
// register is loaded on update, which waits while the response is still held.
// A new request is taken only back in idle, after the controller has committed
// the last one; it may be taken while a response waits.
// Reset: synchronous; empties all frames, zeroes ranks and the fault count,
// sets frames_in_use to 16. No clearing pass.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]  cfg_wdata,
  lrupr_req_if.sink                    req,
  lrupr_rsp_if.source                  rsp
);

  lrupr_pkg::cmd_t cmd;

  lrupr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  lrupr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .action        (req.action),
    .page_number   (req.page_number),
    .hit           (rsp.hit),
    .frame_index   (rsp.frame_index),
    .evicted_valid (rsp.evicted_valid),
    .evicted_page  (rsp.evicted_page),
    .fault_count   (rsp.fault_count)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.look, cmd.update}))
    else $error("controller commands overlap");

  a_capture_then_look: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.look)
    else $error("lookup did not follow capture");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.hit && rsp.evicted_valid))
    else $error("hit reported with eviction");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.evicted_valid) |-> (rsp.evicted_page == '0))
    else $error("evicted page nonzero without eviction");

endmodule

// ----- design/lrupr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer: capture a request, run the frame lookup, then commit the
// update and load the response register once it is free.
// ----------------------------------------------------------------------------
module lrupr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output lrupr_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_valid_next;

  assign req_ready   = (state == S_IDLE);
  assign cmd.capture = req_valid && (state == S_IDLE);
  assign cmd.look    = (state == S_LOOK);
  assign cmd.update  = (state == S_UPD) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (cmd.update) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.update) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ----- design/lrupr_dp.sv -----
// ----------------------------------------------------------------------------
// lrupr_dp
// Frame store with parallel tag match, free-frame and victim selection,
// recency rank update, fault counter and the response register.
// ----------------------------------------------------------------------------
module lrupr_dp #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lrupr_pkg::cmd_t                     cmd,
  input  logic                                cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                                action,
  input  logic [lrupr_pkg::PAGE_W-1:0]        page_number,
  output logic                                hit,
  output logic [lrupr_pkg::FRAME_IDX_W-1:0]   frame_index,
  output logic                                evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]        evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0]       fault_count
);

  localparam int FW   = $clog2(FRAMES);
  localparam int RW   = FW;
  localparam int CMPW = (FW > lrupr_pkg::CFG_W) ? FW : lrupr_pkg::CFG_W;
  localparam logic [RW-1:0] RANK_MAX = RW'(FRAMES - 1);

  logic [lrupr_pkg::CFG_W-1:0]   frames_in_use;
  logic [PAGE_BITS-1:0]          page_q   [FRAMES];
  logic [FRAMES-1:0]             valid_q;
  logic [RW-1:0]                 rank_q   [FRAMES];
  logic [lrupr_pkg::FAULT_W-1:0] faults;

  logic                          act_q;
  logic [PAGE_BITS-1:0]          req_page;

  logic [FRAMES-1:0]             in_use;
  logic [FRAMES-1:0]             match_vec;
  logic [FRAMES-1:0]             free_vec;
  logic [FRAMES-1:0]             victim_vec;
  logic [FRAMES-1:0]             match_first;
  logic [FRAMES-1:0]             free_first;

  logic                          hit_q;
  logic                          fill_q;
  logic [FRAMES-1:0]             sel_q;

  logic [FW-1:0]                 sel_idx;
  logic [RW-1:0]                 sel_rank;
  logic [PAGE_BITS-1:0]          sel_page;
  logic [FRAMES-1:0]             age_vec;
  logic [lrupr_pkg::FAULT_W-1:0] faults_next;

  // Frames in use: frame 0 always, others below the configured count.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      in_use[i] = (i == 0) || (CMPW'(i) < CMPW'(frames_in_use));
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match_vec[i] = in_use[i] && valid_q[i] && (page_q[i] == req_page);
      free_vec[i]  = in_use[i] && !valid_q[i];
    end
  end

  // Victim: highest rank among frames in use, lowest index on ties.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      victim_vec[i] = in_use[i];
      for (int j = 0; j < FRAMES; j++) begin
        if (in_use[j] && (j != i)) begin
          if (j < i) begin
            if (!(rank_q[j] < rank_q[i])) begin
              victim_vec[i] = 1'b0;
            end
          end else begin
            if (rank_q[j] > rank_q[i]) begin
              victim_vec[i] = 1'b0;
            end
          end
        end
      end
    end
  end

  assign match_first = match_vec & (~match_vec + {{(FRAMES-1){1'b0}}, 1'b1});
  assign free_first  = free_vec & (~free_vec + {{(FRAMES-1){1'b0}}, 1'b1});

  always_comb begin
    sel_idx  = '0;
    sel_rank = '0;
    sel_page = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (sel_q[i]) begin
        sel_idx  = sel_idx | FW'(i);
        sel_rank = sel_rank | rank_q[i];
        sel_page = sel_page | page_q[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      age_vec[i] = !sel_q[i] && valid_q[i] && (rank_q[i] < RANK_MAX) &&
                   (fill_q || (rank_q[i] < sel_rank));
    end
  end

  always_comb begin
    if (act_q == lrupr_pkg::ACT_CLEAR) begin
      faults_next = '0;
    end else if (hit_q || (faults == '1)) begin
      faults_next = faults;
    end else begin
      faults_next = faults + lrupr_pkg::FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lrupr_pkg::FRAMES_IN_USE_RST;
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q    <= action;
      req_page <= PAGE_BITS'(page_number);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit_q  <= |match_vec;
      fill_q <= !(|match_vec) && (|free_vec);
      if (|match_vec) begin
        sel_q <= match_first;
      end else if (|free_vec) begin
        sel_q <= free_first;
      end else begin
        sel_q <= victim_vec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
      faults  <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd.update) begin
      faults <= faults_next;
      if (act_q == lrupr_pkg::ACT_CLEAR) begin
        valid_q <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          rank_q[i] <= '0;
        end
      end else begin
        for (int i = 0; i < FRAMES; i++) begin
          if (sel_q[i]) begin
            rank_q[i] <= '0;
          end else if (age_vec[i]) begin
            rank_q[i] <= rank_q[i] + RW'(1);
          end
        end
        if (!hit_q) begin
          valid_q <= valid_q | sel_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && (act_q != lrupr_pkg::ACT_CLEAR) && !hit_q) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (sel_q[i]) begin
          page_q[i] <= req_page;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      fault_count <= faults_next;
      if (act_q == lrupr_pkg::ACT_CLEAR) begin
        hit           <= 1'b0;
        frame_index   <= '0;
        evicted_valid <= 1'b0;
        evicted_page  <= '0;
      end else begin
        hit           <= hit_q;
        frame_index   <= lrupr_pkg::FRAME_IDX_W'(sel_idx);
        evicted_valid <= !hit_q && !fill_q;
        if (!hit_q && !fill_q) begin
          evicted_page <= lrupr_pkg::PAGE_W'(sel_page);
        end else begin
          evicted_page <= '0;
        end
      end
    end
  end

endmodule

// ----- tb/lrupr_checker.sv -----
// ----------------------------------------------------------------------------
// lrupr_checker
// Watches the request, response and configuration ports of the LRU page
// replacement block. It predicts each lookup from its own copy of the frames,
// the recency ranks, the fault count and frames_in_use. It then compares every
// accepted response, field by field, with the oldest pending prediction.
// ----------------------------------------------------------------------------
module lrupr_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata,
  lrupr_req_if                        req,
  lrupr_rsp_if                        rsp,
  output int                          errors,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFR = lrupr_pkg::FRAMES_DEF;

  typedef struct packed {
    logic                              hit;
    logic [lrupr_pkg::FRAME_IDX_W-1:0] frame;
    logic                              evicted;
    logic [lrupr_pkg::PAGE_W-1:0]      evicted_page;
    logic [lrupr_pkg::FAULT_W-1:0]     faults;
  } lookup_t;

  logic [lrupr_pkg::PAGE_W-1:0]  frame_pg  [NFR];
  logic                          frame_vld [NFR];
  int                            frame_age [NFR];
  logic [lrupr_pkg::FAULT_W-1:0] fault_tally;
  logic [lrupr_pkg::CFG_W-1:0]   frames_cfg;
  lookup_t                       due_lookups [$];

  task automatic log_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic void make_recent(input int f, input int limit);
    int i;
    for (i = 0; i < NFR; i++) begin
      if (i != f && frame_vld[i] && frame_age[i] < limit && frame_age[i] < NFR - 1)
        frame_age[i]++;
    end
    frame_age[f] = 0;
  endfunction

  function automatic lookup_t lookup_page(input logic act,
                                          input logic [lrupr_pkg::PAGE_W-1:0] pg);
    lookup_t r;
    int      n;
    int      i;
    int      f;
    int      oldest;
    bit      resident;
    bit      free_slot;
    r = '0;
    f = 0;
    resident = 1'b0;
    free_slot = 1'b0;
    if (act == lrupr_pkg::ACT_CLEAR) begin
      for (i = 0; i < NFR; i++) begin
        frame_vld[i] = 1'b0;
        frame_age[i] = 0;
      end
      fault_tally = '0;
      return r;
    end
    n = (frames_cfg == '0) ? 1 : ((int'(frames_cfg) > NFR) ? NFR : int'(frames_cfg));
    for (i = 0; i < n && !resident; i++) begin
      if (frame_vld[i] && frame_pg[i] == pg) begin
        resident = 1'b1;
        f = i;
      end
    end
    if (resident) begin
      make_recent(f, frame_age[f]);
    end else begin
      for (i = 0; i < n && !free_slot; i++) begin
        if (!frame_vld[i]) begin
          free_slot = 1'b1;
          f = i;
        end
      end
      if (free_slot) begin
        make_recent(f, NFR);
      end else begin
        oldest = 0;
        f = 0;
        for (i = 0; i < n; i++) begin
          if (frame_age[i] > oldest) begin
            oldest = frame_age[i];
            f = i;
          end
        end
        r.evicted = 1'b1;
        r.evicted_page = frame_pg[f];
        make_recent(f, frame_age[f]);
      end
      frame_pg[f] = pg;
      frame_vld[f] = 1'b1;
      if (fault_tally != '1) fault_tally++;
    end
    r.hit = resident;
    r.frame = lrupr_pkg::FRAME_IDX_W'(f);
    r.faults = fault_tally;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      for (int i = 0; i < NFR; i++) begin
        frame_vld[i] = 1'b0;
        frame_age[i] = 0;
      end
      fault_tally = '0;
      frames_cfg = lrupr_pkg::FRAMES_IN_USE_RST;
      due_lookups.delete();
      errors = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (due_lookups.size() == 0) begin
          log_mismatch($sformatf("unexpected item hit=%0b frame=%0d ev=%0b evpage=%h faults=%0d",
                                 rsp.hit, rsp.frame_index, rsp.evicted_valid,
                                 rsp.evicted_page, rsp.fault_count));
        end else begin
          want = due_lookups.pop_front();
          if (rsp.hit !== want.hit)
            log_mismatch($sformatf("hit got %0b want %0b", rsp.hit, want.hit));
          if (rsp.frame_index !== want.frame)
            log_mismatch($sformatf("frame_index got %0d want %0d",
                                   rsp.frame_index, want.frame));
          if (rsp.evicted_valid !== want.evicted)
            log_mismatch($sformatf("evicted_valid got %0b want %0b",
                                   rsp.evicted_valid, want.evicted));
          if (rsp.evicted_page !== want.evicted_page)
            log_mismatch($sformatf("evicted_page got %h want %h",
                                   rsp.evicted_page, want.evicted_page));
          if (rsp.fault_count !== want.faults)
            log_mismatch($sformatf("fault_count got %0d want %0d",
                                   rsp.fault_count, want.faults));
        end
      end
      if (cfg_we) frames_cfg = cfg_wdata;
      if (req.valid && req.ready)
        due_lookups.insert(due_lookups.size(), lookup_page(req.action, req.page_number));
    end
    outstanding <= due_lookups.size();
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the LRU page replacement block: directed references that fill,
// hit, evict and clear frames under several frames_in_use settings, then random
// phases of working-set references and clears, with random gaps on both handshakes
// outside two steady phases. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 60;
  localparam int POOL_N      = 24;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata;
  bit                          steady;
  int                          mismatches;
  int                          backlog;

  lrupr_req_if req_ch();
  lrupr_rsp_if rsp_ch();

  lru_page_replacement uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  lrupr_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .errors      (mismatches),
    .outstanding (backlog)
  );

  logic [lrupr_pkg::PAGE_W-1:0] page_pool [POOL_N];
  logic [lrupr_pkg::CFG_W-1:0]  phase_cfg [PHASES];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 31);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(negedge rst);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  task automatic push_item(input logic act, input logic [lrupr_pkg::PAGE_W-1:0] pg);
    while (!steady && $urandom_range(99) < 31) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.action      <= act;
    req_ch.page_number <= pg;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  task automatic set_frames(input logic [lrupr_pkg::CFG_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int eff;
    int span;
    int roll;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    steady             = 1'b0;
    req_ch.valid       = 1'b0;
    req_ch.action      = lrupr_pkg::ACT_REF;
    req_ch.page_number = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    push_item(lrupr_pkg::ACT_REF, 16'h0000);
    push_item(lrupr_pkg::ACT_REF, 16'h0000);
    push_item(lrupr_pkg::ACT_REF, 16'hFFFF);
    push_item(lrupr_pkg::ACT_REF, 16'h5555);
    push_item(lrupr_pkg::ACT_REF, 16'hAAAA);
    push_item(lrupr_pkg::ACT_CLEAR, 16'h0000);

    set_frames(5'd3);
    push_item(lrupr_pkg::ACT_REF, 16'h0001);
    push_item(lrupr_pkg::ACT_REF, 16'h0002);
    push_item(lrupr_pkg::ACT_REF, 16'h0003);
    push_item(lrupr_pkg::ACT_REF, 16'h0001);
    push_item(lrupr_pkg::ACT_REF, 16'h0004);
    push_item(lrupr_pkg::ACT_REF, 16'h0005);

    set_frames(5'd0);
    push_item(lrupr_pkg::ACT_REF, 16'h0007);
    push_item(lrupr_pkg::ACT_REF, 16'h0007);
    push_item(lrupr_pkg::ACT_REF, 16'hFFFF);

    set_frames(5'd31);
    push_item(lrupr_pkg::ACT_REF, 16'h0008);
    push_item(lrupr_pkg::ACT_REF, 16'h0004);
    push_item(lrupr_pkg::ACT_REF, 16'h0005);
    push_item(lrupr_pkg::ACT_CLEAR, 16'hFFFF);
    push_item(lrupr_pkg::ACT_REF, 16'h0000);

    foreach (page_pool[i]) page_pool[i] = lrupr_pkg::PAGE_W'($urandom);
    phase_cfg = '{5'd16, 5'd1, 5'd8, 5'd31, 5'd2, 5'd17, 5'd0, 5'd5, 5'd12, 5'd3};
    phase_cfg[8] = lrupr_pkg::CFG_W'($urandom_range(1, 16));

    for (int p = 0; p < PHASES; p++) begin
      set_frames(phase_cfg[p]);
      steady = (p == 3 || p == 4);
      eff = (phase_cfg[p] == '0) ? 1 : ((phase_cfg[p] > 5'd16) ? 16 : int'(phase_cfg[p]));
      span = (eff + 2 > POOL_N - 1) ? POOL_N - 1 : eff + 2;
      repeat (3) page_pool[$urandom_range(POOL_N - 1)] = lrupr_pkg::PAGE_W'($urandom);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 6 && k == PHASE_ITEMS / 2) drain();
        roll = $urandom_range(99);
        if (roll < 2)
          push_item(lrupr_pkg::ACT_CLEAR, lrupr_pkg::PAGE_W'($urandom));
        else if (roll < 82)
          push_item(lrupr_pkg::ACT_REF, page_pool[$urandom_range(span)]);
        else
          push_item(lrupr_pkg::ACT_REF, lrupr_pkg::PAGE_W'($urandom));
      end
    end

    steady = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && backlog == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- lru_page_replacement.f -----
design/lrupr_pkg.sv
design/lrupr_req_if.sv
design/lrupr_rsp_if.sv
design/lrupr_ctrl.sv
design/lrupr_dp.sv
design/lru_page_replacement.sv
tb/lrupr_checker.sv
tb/tb.sv
